/* design/psfp_pkg.sv */
`default_nettype none

package psfp_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned WordW = 16;
  localparam int unsigned PosW  = 4;

  localparam logic [ByteW-1:0] HEAD_BYTE    = 8'hAA;
  localparam logic [ByteW-1:0] COMMAND_BYTE = 8'hC0;
  localparam logic [ByteW-1:0] TAIL_BYTE    = 8'hAB;

  // Frame positions: the slot that the next byte fills
  localparam logic [PosW-1:0] POS_HEAD     = 4'd0;
  localparam logic [PosW-1:0] POS_CMD      = 4'd1;
  localparam logic [PosW-1:0] POS_FINE_LO  = 4'd2;
  localparam logic [PosW-1:0] POS_FINE_HI  = 4'd3;
  localparam logic [PosW-1:0] POS_COARSE_LO = 4'd4;
  localparam logic [PosW-1:0] POS_COARSE_HI = 4'd5;
  localparam logic [PosW-1:0] POS_ID_HI    = 4'd6;
  localparam logic [PosW-1:0] POS_ID_LO    = 4'd7;
  localparam logic [PosW-1:0] POS_CHECK    = 4'd8;
  localparam logic [PosW-1:0] POS_TAIL     = 4'd9;

endpackage

`default_nettype wire

/* design/particulate_sensor_frame_parser.sv */
`default_nettype none

// Channel  Ports                                             Direction
// in       in_valid, in_ready, in_rx_byte                    byte from sensor link
// out      out_valid, out_ready, out_fine_dust_tenths,       one result per good frame
//          out_coarse_dust_tenths, out_sensor_id
//
// One byte per cycle sustained, except while a good tail is held by a stall on out. A byte
// sits in the input register, is parsed against the frame position there, and a good tail
// loads the result register, so the tail byte passes the input register and then the result register.
// Reset clears the valid flags, the frame position and the accumulators.
// A stall on out holds the input register only when it carries a good tail.
module particulate_sensor_frame_parser (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_rx_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_fine_dust_tenths,
  output logic [15:0]      out_coarse_dust_tenths,
  output logic [15:0]      out_sensor_id
);
  import psfp_pkg::*;

  logic             stg_vld_r;
  logic [ByteW-1:0] stg_byte_r;

  logic [PosW-1:0]  pos_r,    pos_nxt;
  logic [WordW-1:0] fine_r,   fine_nxt;
  logic [WordW-1:0] coarse_r, coarse_nxt;
  logic [WordW-1:0] id_r,     id_nxt;
  logic [ByteW-1:0] sum_r,    sum_nxt;
  logic             produce;

  logic             out_vld_r;
  logic [WordW-1:0] out_fine_r, out_coarse_r, out_id_r;

  logic out_free;
  logic stg_adv;

  assign out_free = !out_vld_r || out_ready;
  assign stg_adv  = stg_vld_r && (!produce || out_free);
  assign in_ready = !stg_vld_r || stg_adv;

  always_comb begin
    pos_nxt    = pos_r + 4'd1;
    fine_nxt   = fine_r;
    coarse_nxt = coarse_r;
    id_nxt     = id_r;
    sum_nxt    = sum_r;
    produce    = 1'b0;
    unique case (pos_r)
      POS_CMD: begin
        if (stg_byte_r != COMMAND_BYTE) pos_nxt = POS_HEAD;
      end
      POS_FINE_LO: begin
        fine_nxt = {8'h00, stg_byte_r};
        sum_nxt  = stg_byte_r;
      end
      POS_FINE_HI: begin
        fine_nxt = {stg_byte_r, fine_r[7:0]};
        sum_nxt  = sum_r + stg_byte_r;
      end
      POS_COARSE_LO: begin
        coarse_nxt = {8'h00, stg_byte_r};
        sum_nxt    = sum_r + stg_byte_r;
      end
      POS_COARSE_HI: begin
        coarse_nxt = {stg_byte_r, coarse_r[7:0]};
        sum_nxt    = sum_r + stg_byte_r;
      end
      POS_ID_HI: begin
        id_nxt  = {stg_byte_r, 8'h00};
        sum_nxt = sum_r + stg_byte_r;
      end
      POS_ID_LO: begin
        id_nxt  = {id_r[15:8], stg_byte_r};
        sum_nxt = sum_r + stg_byte_r;
      end
      POS_CHECK: begin
        if (stg_byte_r != sum_r) pos_nxt = POS_HEAD;
      end
      POS_TAIL: begin
        pos_nxt = POS_HEAD;
        produce = (stg_byte_r == TAIL_BYTE);
      end
      default: begin
        // hunt for the head; unused positions hunt too
        pos_nxt = (stg_byte_r == HEAD_BYTE) ? POS_CMD : POS_HEAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
      pos_r     <= POS_HEAD;
      fine_r    <= '0;
      coarse_r  <= '0;
      id_r      <= '0;
      sum_r     <= '0;
    end else begin
      if (in_ready) stg_vld_r <= in_valid;
      if (stg_adv) begin
        pos_r    <= pos_nxt;
        fine_r   <= fine_nxt;
        coarse_r <= coarse_nxt;
        id_r     <= id_nxt;
        sum_r    <= sum_nxt;
      end
      if (stg_adv && produce) out_vld_r <= 1'b1;
      else if (out_ready)     out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) stg_byte_r <= in_rx_byte;
    if (stg_adv && produce) begin
      out_fine_r   <= fine_r;
      out_coarse_r <= coarse_r;
      out_id_r     <= id_r;
    end
  end

  assign out_valid              = out_vld_r;
  assign out_fine_dust_tenths   = out_fine_r;
  assign out_coarse_dust_tenths = out_coarse_r;
  assign out_sensor_id          = out_id_r;

endmodule

`default_nettype wire
